@@ rtl/mdbr_pkg.sv @@
// shared types, constants and codes for the microphone dc-block recorder
`default_nettype none
package mdbr_pkg;

  // converter and filter constants
  localparam int unsigned AdcW       = 12;
  localparam int unsigned VolW       = 7;
  localparam int unsigned BufSizeW   = 11;
  localparam int unsigned AddrW      = 10;
  localparam int unsigned CountW     = 32;
  localparam int unsigned WordW      = 16;
  localparam int unsigned FiltW      = 24;
  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned MicOffset  = 1705;
  localparam int unsigned ClampLimit = 32760;
  localparam int unsigned WordBias   = 32768;

  // reciprocal of 100: ceil(2^26 / 100), exact for magnitudes below 2^19
  localparam int unsigned RecipShift = 26;
  localparam int unsigned RecipMul   = (1 << RecipShift) / 100 + 1;

  // configuration register indexes
  localparam logic CFG_VOLUME   = 1'b0;
  localparam logic CFG_BUF_SIZE = 1'b1;

  // reset values of the configuration registers
  localparam logic [VolW-1:0]     VolumeReset  = VolW'(100);
  localparam logic [BufSizeW-1:0] BufSizeReset = BufSizeW'(1024);

  // input command codes
  typedef enum logic [2:0] {
    CMD_SAMPLE = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4
  } cmd_t;

  // record mode kept by the front end
  typedef enum logic [1:0] {
    MODE_READY     = 2'd0,
    MODE_RECORDING = 2'd1,
    MODE_PAUSED    = 2'd2
  } mode_t;

  // work for the back end after classification
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FILT = 2'd2,
    BK_DONE = 2'd3
  } back_state_t;

  // classified word travelling through the queue
  typedef struct packed {
    op_t             op;
    logic            status;
    logic [AdcW-1:0] adc;
  } item_t;

  // one result word
  typedef struct packed {
    logic              status;
    logic              sample_stored;
    logic [WordW-1:0]  stored_word;
    logic [AddrW-1:0]  write_address;
    logic              buffer_full;
    logic [CountW-1:0] samples_recorded;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/mdbr_front.sv @@
// front end: accepts words, tracks the record mode and classifies each word
`default_nettype none
module mdbr_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [2:0]                command,
  input  wire logic [mdbr_pkg::AdcW-1:0] adc_sample,
  output mdbr_pkg::item_t                item
);

  mdbr_pkg::mode_t mode_r, mode_nxt;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mdbr_pkg::MODE_READY;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

  // classification and next mode
  always_comb begin
    mode_nxt    = mode_r;
    item.op     = mdbr_pkg::OP_NONE;
    item.status = 1'b0;
    item.adc    = adc_sample;
    unique case (command)
      mdbr_pkg::CMD_SAMPLE: begin
        if (mode_r == mdbr_pkg::MODE_RECORDING) begin
          item.op = mdbr_pkg::OP_SAMPLE;
        end
      end
      mdbr_pkg::CMD_START: begin
        if (mode_r == mdbr_pkg::MODE_READY) begin
          item.op  = mdbr_pkg::OP_CLEAR;
          mode_nxt = mdbr_pkg::MODE_RECORDING;
        end else if (mode_r == mdbr_pkg::MODE_PAUSED) begin
          mode_nxt = mdbr_pkg::MODE_RECORDING;
        end else begin
          item.status = 1'b1;
        end
      end
      mdbr_pkg::CMD_STOP: begin
        if (mode_r == mdbr_pkg::MODE_RECORDING || mode_r == mdbr_pkg::MODE_PAUSED) begin
          mode_nxt = mdbr_pkg::MODE_READY;
        end else begin
          item.status = 1'b1;
        end
      end
      mdbr_pkg::CMD_PAUSE: begin
        if (mode_r == mdbr_pkg::MODE_RECORDING) begin
          mode_nxt = mdbr_pkg::MODE_PAUSED;
        end else begin
          item.status = 1'b1;
        end
      end
      mdbr_pkg::CMD_RESUME: begin
        if (mode_r == mdbr_pkg::MODE_PAUSED) begin
          mode_nxt = mdbr_pkg::MODE_RECORDING;
        end else begin
          item.status = 1'b1;
        end
      end
      default: begin
        item.status = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/mdbr_queue.sv @@
// two-word queue between the front end and the back end
`default_nettype none
module mdbr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire mdbr_pkg::item_t wr_item,
  input  wire logic            rd_en,
  output mdbr_pkg::item_t      rd_item,
  output logic                 full,
  output logic                 empty
);

  mdbr_pkg::item_t slot_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    count_nxt  = count_r + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item = slot_r[rd_ptr_r];
  assign full    = count_r[1];
  assign empty   = (count_r == 2'd0);

endmodule
`default_nettype wire

@@ rtl/mdbr_back.sv @@
// back end: scaling, dc-block filter, buffer position, count and result register
`default_nettype none
module mdbr_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [mdbr_pkg::BufSizeW-1:0] cfg_data,
  input  wire logic                          q_empty,
  input  wire mdbr_pkg::item_t               q_item,
  output logic                               q_pop,
  output logic                               res_valid,
  output mdbr_pkg::result_t                  res,
  input  wire logic                          res_pop
);

  localparam int unsigned MagW  = 19;
  localparam int unsigned MulW  = 20;
  localparam int unsigned ProdW = MagW + MulW;
  localparam int unsigned ZW    = 13;
  localparam int unsigned SumW  = mdbr_pkg::FiltW + 2;
  localparam int unsigned FProdW = SumW + 9;

  mdbr_pkg::back_state_t state_r, state_nxt;

  logic [mdbr_pkg::VolW-1:0]     volume_r;
  logic [mdbr_pkg::BufSizeW-1:0] buf_size_r;

  mdbr_pkg::op_t                 op_r;
  logic                          status_r;
  logic signed [20:0]            scaled_r;
  logic                          neg_r;
  logic [ProdW-1:0]              recip_r;
  logic signed [mdbr_pkg::FiltW-1:0] y_r;
  logic signed [mdbr_pkg::FiltW-1:0] yprev_r;
  logic signed [mdbr_pkg::WordW-1:0] zprev_r;
  logic [mdbr_pkg::AddrW-1:0]    wpos_r;
  logic [mdbr_pkg::CountW-1:0]   count_r;
  logic                          res_valid_r;
  mdbr_pkg::result_t             res_r;

  logic                          res_write;
  logic signed [12:0]            x;
  logic [MagW-1:0]               mag;
  logic [11:0]                   z_abs;
  logic signed [ZW-1:0]          z;
  logic signed [mdbr_pkg::WordW-1:0] z8;
  logic signed [SumW-1:0]        fsum;
  logic signed [FProdW-1:0]      fprod;
  logic signed [FProdW-1:0]      fadj;
  logic signed [FProdW-1:0]      fshift;
  logic signed [mdbr_pkg::WordW-1:0] clamped;
  logic [mdbr_pkg::BufSizeW-1:0] next_pos;
  logic                          wrap;
  mdbr_pkg::result_t             res_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r   <= mdbr_pkg::VolumeReset;
      buf_size_r <= mdbr_pkg::BufSizeReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdbr_pkg::CFG_VOLUME:   volume_r   <= cfg_data[mdbr_pkg::VolW-1:0];
        mdbr_pkg::CFG_BUF_SIZE: buf_size_r <= cfg_data;
        default:                ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdbr_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    res_write = 1'b0;
    unique case (state_r)
      mdbr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_item.op == mdbr_pkg::OP_SAMPLE) begin
            state_nxt = mdbr_pkg::BK_DIV;
          end else begin
            state_nxt = mdbr_pkg::BK_DONE;
          end
        end
      end
      mdbr_pkg::BK_DIV: begin
        state_nxt = mdbr_pkg::BK_FILT;
      end
      mdbr_pkg::BK_FILT: begin
        state_nxt = mdbr_pkg::BK_DONE;
      end
      mdbr_pkg::BK_DONE: begin
        if (!res_valid_r || res_pop) begin
          res_write = 1'b1;
          state_nxt = mdbr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mdbr_pkg::BK_IDLE;
      end
    endcase
  end

  // offset removal; the volume product is taken in the datapath registers
  assign x = $signed({1'b0, q_item.adc}) - 13'sd1705;

  // magnitude of the product for the reciprocal divide
  assign mag = scaled_r[20] ? MagW'(-scaled_r) : MagW'(scaled_r);

  // quotient by 100, sign restored, then times 8
  assign z_abs = recip_r[mdbr_pkg::RecipShift +: 12];
  assign z     = neg_r ? -$signed({1'b0, z_abs}) : $signed({1'b0, z_abs});
  assign z8    = $signed({z, 3'b000});

  // dc-block filter: 248 * (y + x - xprev) / 256, truncated toward zero
  assign fsum   = SumW'(yprev_r) + SumW'(z8) - SumW'(zprev_r);
  assign fprod  = (FProdW'(fsum) <<< 8) - (FProdW'(fsum) <<< 3);
  assign fadj   = fprod[FProdW-1] ? fprod + FProdW'(255) : fprod;
  assign fshift = fadj >>> 8;

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == mdbr_pkg::BK_IDLE && !q_empty) begin
      op_r     <= q_item.op;
      status_r <= q_item.status;
      scaled_r <= 21'(x) * 21'($signed({1'b0, volume_r}));
    end
    if (state_r == mdbr_pkg::BK_DIV) begin
      neg_r   <= scaled_r[20];
      recip_r <= ProdW'(mag) * ProdW'(mdbr_pkg::RecipMul);
    end
  end

  // filter state, cleared only by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yprev_r <= '0;
      zprev_r <= '0;
    end else if (state_r == mdbr_pkg::BK_FILT) begin
      yprev_r <= fshift[mdbr_pkg::FiltW-1:0];
      zprev_r <= z8;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mdbr_pkg::BK_FILT) begin
      y_r <= fshift[mdbr_pkg::FiltW-1:0];
    end
  end

  // clamp and next buffer position
  always_comb begin
    if (y_r > $signed(mdbr_pkg::FiltW'(mdbr_pkg::ClampLimit))) begin
      clamped = 16'sd32760;
    end else if (y_r < -$signed(mdbr_pkg::FiltW'(mdbr_pkg::ClampLimit))) begin
      clamped = -16'sd32760;
    end else begin
      clamped = y_r[mdbr_pkg::WordW-1:0];
    end
    next_pos = mdbr_pkg::BufSizeW'(wpos_r) + mdbr_pkg::BufSizeW'(1);
    wrap     = (next_pos >= buf_size_r) ||
               (next_pos >= mdbr_pkg::BufSizeW'(mdbr_pkg::MaxEntries));
  end

  // result word assembly
  always_comb begin
    res_nxt                  = '0;
    res_nxt.status           = status_r;
    res_nxt.samples_recorded = count_r;
    unique case (op_r)
      mdbr_pkg::OP_SAMPLE: begin
        res_nxt.sample_stored    = 1'b1;
        res_nxt.stored_word      = clamped + mdbr_pkg::WordW'(mdbr_pkg::WordBias);
        res_nxt.write_address    = wpos_r;
        res_nxt.buffer_full      = wrap;
        res_nxt.samples_recorded = count_r + mdbr_pkg::CountW'(1);
      end
      mdbr_pkg::OP_CLEAR: begin
        res_nxt.samples_recorded = '0;
      end
      default: ;
    endcase
  end

  // buffer position and sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= '0;
      count_r <= '0;
    end else if (res_write) begin
      unique case (op_r)
        mdbr_pkg::OP_SAMPLE: begin
          wpos_r  <= wrap ? '0 : next_pos[mdbr_pkg::AddrW-1:0];
          count_r <= count_r + mdbr_pkg::CountW'(1);
        end
        mdbr_pkg::OP_CLEAR: begin
          wpos_r  <= '0;
          count_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_write) begin
      res_valid_r <= 1'b1;
    end else if (res_pop) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

@@ rtl/mic_sample_dc_block_recorder.sv @@
// top level of the microphone sample recorder with dc-blocking filter
//
//  channel | direction | handshake       | payload
//  --------+-----------+-----------------+------------------------------------------
//  in      | input     | in_push/in_full | command, adc_sample
//  out     | output    | out_empty/pop   | status, sample_stored, stored_word,
//          |           |                 | write_address, buffer_full, samples_recorded
//  cfg     | input     | cfg_we          | cfg_index, cfg_data
//
// a sample passes the back-end sequencer steps in order (volume multiply, reciprocal
// divide by 100, filter, result write); a command goes straight to the result write
// the back end works on one word at a time; a two-word queue in front of it
// takes up to two more words while it is busy
// a finished result waits in the output register; until it is popped the back end
// holds its next result, the queue fills and in_full rises
// reset is synchronous and active low and clears mode, position, count and filter
`default_nettype none
module mic_sample_dc_block_recorder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [2:0]                    in_command,
  input  wire logic [mdbr_pkg::AdcW-1:0]     in_adc_sample,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_status,
  output logic                               out_sample_stored,
  output logic [mdbr_pkg::WordW-1:0]         out_stored_word,
  output logic [mdbr_pkg::AddrW-1:0]         out_write_address,
  output logic                               out_buffer_full,
  output logic [mdbr_pkg::CountW-1:0]        out_samples_recorded,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [mdbr_pkg::BufSizeW-1:0] cfg_data
);

  logic              accept;
  mdbr_pkg::item_t   front_item;
  mdbr_pkg::item_t   q_item;
  logic              q_empty;
  logic              q_pop;
  logic              res_valid;
  mdbr_pkg::result_t res;

  // input accept
  assign accept = in_push && !in_full;

  mdbr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .adc_sample (in_adc_sample),
    .item       (front_item)
  );

  mdbr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_item (front_item),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .full    (in_full),
    .empty   (q_empty)
  );

  mdbr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (out_pop)
  );

  // result ports
  assign out_empty            = !res_valid;
  assign out_status           = res.status;
  assign out_sample_stored    = res.sample_stored;
  assign out_stored_word      = res.stored_word;
  assign out_write_address    = res.write_address;
  assign out_buffer_full      = res.buffer_full;
  assign out_samples_recorded = res.samples_recorded;

endmodule
`default_nettype wire

@@ tb/sv/tb_mic_sample_dc_block_recorder.sv @@
// self-checking testbench for the microphone dc-block recorder
`timescale 1ns / 100ps

import mdbr_pkg::*;

// tracks record mode, buffer position and filter state, and holds the expected words
class dc_block_tracker;
  result_t                 expected_words[$];
  int                      errors;
  mode_t                   mode;
  logic [VolW-1:0]         volume;
  logic [BufSizeW-1:0]     buffer_size;
  logic [AddrW-1:0]        write_pos;
  logic [CountW-1:0]       sample_count;
  logic signed [FiltW-1:0] last_out;
  logic signed [WordW-1:0] last_in;
  bit                      saw_max_wrap;

  function new();
    errors       = 0;
    mode         = MODE_READY;
    volume       = VolumeReset;
    buffer_size  = BufSizeReset;
    write_pos    = '0;
    sample_count = '0;
    last_out     = '0;
    last_in      = '0;
    saw_max_wrap = 1'b0;
  endfunction

  function void set_register(input logic idx, input logic [BufSizeW-1:0] data);
    if (idx == CFG_VOLUME) begin
      volume = data[VolW-1:0];
    end else begin
      buffer_size = data;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction

  // filter and record one accepted input word, queue the word it should produce
  function void accept_word(input logic [2:0] cmd, input logic [AdcW-1:0] adc);
    result_t                 w;
    longint                  centered;
    longint                  scaled;
    longint                  filt;
    longint                  clamped;
    logic signed [WordW-1:0] scaled16;
    int unsigned             nxt;
    w = '0;
    case (cmd)
      CMD_SAMPLE: begin
        if (mode == MODE_RECORDING) begin
          // offset removal, volume scaling and extra gain
          centered = longint'(adc) - longint'(MicOffset);
          scaled   = (centered * longint'(volume)) / 100;
          scaled16 = WordW'(scaled * 8);
          // dc-blocking high pass, truncating toward zero
          filt = (248 * (longint'(last_out) + longint'(scaled16) - longint'(last_in))) / 256;
          last_out = FiltW'(filt);
          last_in  = scaled16;
          clamped  = longint'(last_out);
          if (clamped > longint'(ClampLimit)) clamped = longint'(ClampLimit);
          if (clamped < -longint'(ClampLimit)) clamped = -longint'(ClampLimit);
          w.sample_stored = 1'b1;
          w.stored_word   = WordW'(clamped + longint'(WordBias));
          w.write_address = write_pos;
          // circular position, wraps at the size or the hard maximum
          nxt = write_pos + 1;
          if (nxt >= buffer_size || nxt >= MaxEntries) begin
            nxt = 0;
            w.buffer_full = 1'b1;
            if (buffer_size > MaxEntries) saw_max_wrap = 1'b1;
          end
          write_pos    = AddrW'(nxt);
          sample_count = sample_count + 1;
        end
      end
      CMD_START: begin
        if (mode == MODE_READY) begin
          write_pos    = '0;
          sample_count = '0;
          mode         = MODE_RECORDING;
        end else if (mode == MODE_PAUSED) begin
          mode = MODE_RECORDING;
        end else begin
          w.status = 1'b1;
        end
      end
      CMD_STOP: begin
        if (mode == MODE_RECORDING || mode == MODE_PAUSED) mode = MODE_READY;
        else w.status = 1'b1;
      end
      CMD_PAUSE: begin
        if (mode == MODE_RECORDING) mode = MODE_PAUSED;
        else w.status = 1'b1;
      end
      CMD_RESUME: begin
        if (mode == MODE_PAUSED) mode = MODE_RECORDING;
        else w.status = 1'b1;
      end
      default: w.status = 1'b1;
    endcase
    w.samples_recorded = sample_count;
    expected_words.push_back(w);
  endfunction

  task report(input string what, input longint unsigned got, input longint unsigned want);
    $display("mismatch: %s got 0x%0h want 0x%0h", what, got, want);
    errors++;
  endtask

  task compare_field(input string name, input longint unsigned got,
                     input longint unsigned want);
    if (got != want) report(name, got, want);
  endtask

  // compare a popped word with the oldest expectation
  task check_word(input result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      report("word with nothing expected", got.samples_recorded, 0);
    end else begin
      want = expected_words.pop_front();
      compare_field("status", got.status, want.status);
      compare_field("sample_stored", got.sample_stored, want.sample_stored);
      compare_field("stored_word", got.stored_word, want.stored_word);
      compare_field("write_address", got.write_address, want.write_address);
      compare_field("buffer_full", got.buffer_full, want.buffer_full);
      compare_field("samples_recorded", got.samples_recorded, want.samples_recorded);
    end
  endtask
endclass

module tb_mic_sample_dc_block_recorder;

  localparam int CycleLimit = 600000;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_push       = 1'b0;
  logic [2:0]          in_command    = '0;
  logic [AdcW-1:0]     in_adc_sample = '0;
  logic                out_pop       = 1'b0;
  logic                cfg_we        = 1'b0;
  logic                cfg_index     = 1'b0;
  logic [BufSizeW-1:0] cfg_data      = '0;

  wire                 in_full;
  wire                 out_empty;
  wire                 out_status;
  wire                 out_sample_stored;
  wire [WordW-1:0]     out_stored_word;
  wire [AddrW-1:0]     out_write_address;
  wire                 out_buffer_full;
  wire [CountW-1:0]    out_samples_recorded;

  dc_block_tracker tracker;
  bit              gaps_on = 1'b1;
  int              cycle_count = 0;

  mic_sample_dc_block_recorder u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_command           (in_command),
    .in_adc_sample        (in_adc_sample),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_status           (out_status),
    .out_sample_stored    (out_sample_stored),
    .out_stored_word      (out_stored_word),
    .out_write_address    (out_write_address),
    .out_buffer_full      (out_buffer_full),
    .out_samples_recorded (out_samples_recorded),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // converter value, biased toward the range ends and the offset
  function automatic logic [AdcW-1:0] random_adc();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return AdcW'(MicOffset);
      3:       return AdcW'(1) << $urandom_range(0, AdcW - 1);
      default: return AdcW'($urandom_range(0, 4095));
    endcase
  endfunction

  // push one word, with an optional idle burst in front
  task automatic send_word(input logic [2:0] cmd, input logic [AdcW-1:0] adc);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_command    <= cmd;
    in_adc_sample <= adc;
    do @(posedge clk); while (in_full);
    tracker.accept_word(cmd, adc);
  endtask

  // stop pushing and wait until every expected word has come back
  task automatic drain();
    in_push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write both registers on consecutive edges while the block is idle
  task automatic configure(input logic [BufSizeW-1:0] vol, input logic [BufSizeW-1:0] size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VOLUME;
    cfg_data  <= vol;
    @(posedge clk);
    tracker.set_register(CFG_VOLUME, vol);
    cfg_index <= CFG_BUF_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    tracker.set_register(CFG_BUF_SIZE, size);
    cfg_we <= 1'b0;
  endtask

  // a command that may or may not be legal in the current mode
  task automatic send_noise(input bit allow_stop);
    logic [2:0] cmd;
    cmd = 3'($urandom_range(0, 7));
    if (!allow_stop && cmd == CMD_STOP) cmd = CMD_SAMPLE;
    send_word(cmd, random_adc());
  endtask

  // mostly well-formed record sequences with random sample content
  task automatic send_random_sequence(input bit allow_stop);
    int pick;
    pick = $urandom_range(0, 99);
    if (tracker.mode != MODE_RECORDING && pick < 70) begin
      send_word(pick < 35 ? CMD_START : CMD_RESUME, random_adc());
    end else if (pick < 80) begin
      send_word(CMD_SAMPLE, random_adc());
    end else if (pick < 86) begin
      send_word(CMD_PAUSE, random_adc());
      repeat ($urandom_range(0, 3)) send_noise(allow_stop);
      send_word(CMD_RESUME, random_adc());
    end else if (pick < 90 && allow_stop) begin
      send_word(CMD_STOP, random_adc());
      repeat ($urandom_range(0, 2)) send_noise(allow_stop);
      send_word(CMD_START, random_adc());
    end else begin
      send_noise(allow_stop);
    end
  endtask

  // result side: random stall bursts, check every popped word
  initial begin : pop_side
    int      stall_left;
    result_t got;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.status           = out_status;
        got.sample_stored    = out_sample_stored;
        got.stored_word      = out_stored_word;
        got.write_address    = out_write_address;
        got.buffer_full      = out_buffer_full;
        got.samples_recorded = out_samples_recorded;
        tracker.check_word(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [BufSizeW-1:0] vol_plan[6];
    logic [BufSizeW-1:0] size_plan[6];
    int                  n;
    vol_plan  = '{11'd0, 11'd127, 11'd1, 11'h7E4, 11'd50, 11'd0};
    size_plan = '{11'd1, 11'd0, 11'd3, 11'd1025, 11'd1024, 11'd0};
    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: illegal commands in ready, range ends, pause and restart paths
    send_word(CMD_SAMPLE, 12'd2048);
    send_word(CMD_STOP, '0);
    send_word(CMD_PAUSE, '0);
    send_word(CMD_RESUME, '0);
    send_word(3'd5, '1);
    send_word(3'd6, '0);
    send_word(3'd7, '1);
    send_word(CMD_START, '0);
    send_word(CMD_START, '0);
    send_word(CMD_RESUME, '0);
    send_word(CMD_SAMPLE, '0);
    send_word(CMD_SAMPLE, '1);
    send_word(CMD_SAMPLE, '1);
    send_word(CMD_SAMPLE, AdcW'(MicOffset));
    send_word(CMD_SAMPLE, '0);
    send_word(CMD_PAUSE, '0);
    send_word(CMD_SAMPLE, 12'hAAA);
    send_word(CMD_PAUSE, '0);
    send_word(CMD_START, '0);
    send_word(CMD_SAMPLE, 12'h555);
    send_word(CMD_PAUSE, '0);
    send_word(CMD_RESUME, '0);
    send_word(CMD_STOP, '0);
    send_word(CMD_STOP, '0);
    send_word(CMD_START, '0);
    send_word(CMD_SAMPLE, 12'd1);
    drain();

    // short phases over register extremes and odd sizes
    vol_plan[5]  = BufSizeW'($urandom_range(0, 127));
    size_plan[5] = BufSizeW'($urandom_range(1, 64));
    for (int p = 0; p < 6; p++) begin
      configure(vol_plan[p], size_plan[p]);
      repeat (10) send_random_sequence(1'b1);
      drain();
    end

    // long recording without stop, until the position wraps at the hard maximum
    configure(11'd127, 11'd2047);
    n = 0;
    while (!tracker.saw_max_wrap && n < 4000) begin
      if (tracker.mode != MODE_RECORDING) begin
        send_word(CMD_START, random_adc());
      end else if ($urandom_range(0, 9) == 0) begin
        send_random_sequence(1'b0);
      end else begin
        send_word(CMD_SAMPLE, random_adc());
      end
      n++;
    end

    // closing stretch with no idling on either side
    gaps_on = 1'b0;
    repeat (40) send_random_sequence(1'b1);
    drain();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
